// File: hw/rtl/psw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_pkg: shared types and constants of the square-wave pattern buffer
// Opcodes, register indexes, field widths, controller states and
// parameter defaults.
// ----------------------------------------------------------------------------
package psw_pkg;

  // parameter defaults
  localparam int RESOLUTION_DEF = 256;
  localparam int CHANNELS_DEF   = 5;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int PORT_W    = 3;
  localparam int WORD_W    = 16;
  localparam int PHASE_W   = 16;
  localparam int INDEX_W   = 8;
  localparam int OFFSET_W  = 8;
  localparam int CFG_IDX_W = 3;

  // phase sum: two 16-bit terms plus an 8-bit offset
  localparam int SUM_W = 18;

  // number of port offset registers
  localparam int NUM_OFFSETS = 5;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PORT_OFFSET_0 = 3'd0,
    REG_PORT_OFFSET_1 = 3'd1,
    REG_PORT_OFFSET_2 = 3'd2,
    REG_PORT_OFFSET_3 = 3'd3,
    REG_PORT_OFFSET_4 = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_START,
    S_RUN,
    S_DRAIN,
    S_RD_ADDR,
    S_RD_DATA
  } state_t;

endpackage

// File: hw/rtl/psw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_if: command and response channels of the pattern buffer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface psw_cmd_if;
  import psw_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [PORT_W-1:0]  port;
  logic [WORD_W-1:0]  pin_mask;
  logic [PHASE_W-1:0] calibration;
  logic [PHASE_W-1:0] shift;
  logic [INDEX_W-1:0] index;

  modport source (
    output valid, operation, port, pin_mask, calibration, shift, index,
    input  ready
  );
  modport sink (
    input  valid, operation, port, pin_mask, calibration, shift, index,
    output ready
  );
endinterface

interface psw_rsp_if;
  import psw_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: hw/rtl/phased_square_wave_pattern_buffer_unit.sv
`timescale 1ns / 1ps
// Add: accept, phase reduction, start, RESOLUTION/2 word updates and a drain step;
//   one word read-modify-write a cycle.
// Clear: every word of the store is written with zero, one word written a cycle.
// Read: S_RD_ADDR reads the store, S_RD_DATA captures the word; result register frees input.
// Reset clears the offsets and runs a clearing pass over all CHANNELS*RESOLUTION words
//   of the store, during which no item is accepted.
// ----------------------------------------------------------------------------
// phased_square_wave_pattern_buffer_unit: square-wave pattern buffer
// Keeps one pattern per port and ORs phase-shifted 50% square waves
// into it under a small sequencer.
// ----------------------------------------------------------------------------
module phased_square_wave_pattern_buffer_unit #(
  parameter int RESOLUTION = psw_pkg::RESOLUTION_DEF,
  parameter int CHANNELS   = psw_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  psw_cmd_if.sink                         cmd,
  psw_rsp_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [psw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psw_pkg::OFFSET_W-1:0]    cfg_data
);
  import psw_pkg::*;

  localparam int RES_W  = $clog2(RESOLUTION);
  localparam int DEPTH  = CHANNELS * RESOLUTION;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int HALF   = RESOLUTION / 2;
  localparam int CNT_W  = $clog2(HALF + 1);

  state_t state, state_next;

  logic [OFFSET_W-1:0] offsets [NUM_OFFSETS];

  logic [PORT_W-1:0]  port_reg;
  logic [WORD_W-1:0]  mask_reg;
  logic [INDEX_W-1:0] idx_reg;
  logic               rd_zero;
  logic [ADDR_W-1:0]  clr_addr;
  logic [RES_W-1:0]   pos;
  logic [CNT_W-1:0]   cnt;
  logic               wr_pend;
  logic [ADDR_W-1:0]  wr_addr;
  logic               out_valid;
  logic [WORD_W-1:0]  out_data;

  logic               accept;
  logic               port_ok;
  logic               index_ok;
  logic [OFFSET_W-1:0] port_off;
  logic [SUM_W-1:0]   sum;
  logic               out_free;
  logic [ADDR_W-1:0]  base;

  logic               mod_start;
  logic               mod_done;
  logic [RES_W-1:0]   phase;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  // decode the incoming item
  assign accept   = cmd.valid && cmd.ready;
  assign port_ok  = 32'(cmd.port) < CHANNELS;
  assign index_ok = 32'(cmd.index) < RESOLUTION;
  assign port_off = (cmd.port < PORT_W'(NUM_OFFSETS)) ? offsets[cmd.port] : '0;
  assign sum      = SUM_W'(cmd.calibration) + SUM_W'(cmd.shift) + SUM_W'(port_off);

  assign out_free = !out_valid || rsp.ready;
  assign base     = ADDR_W'(port_reg) * ADDR_W'(RESOLUTION);

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  // phase reduction unit
  psw_mod_unit #(
    .RESOLUTION (RESOLUTION)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .sum   (sum),
    .done  (mod_done),
    .phase (phase)
  );

  // pattern store
  psw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (op_t'(cmd.operation))
            OP_CLEAR: state_next = S_CLEAR;
            OP_ADD:   state_next = port_ok ? S_MOD : S_IDLE;
            OP_READ:  state_next = S_RD_ADDR;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = S_START;
        end
      end
      S_START:   state_next = S_RUN;
      S_RUN: begin
        if (cnt == CNT_W'(HALF - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:   state_next = S_IDLE;
      S_RD_ADDR: state_next = S_RD_DATA;
      S_RD_DATA: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd.ready = 1'b0;
    mod_start = 1'b0;
    ram_we    = wr_pend;
    ram_waddr = wr_addr;
    ram_wdata = ram_rdata | mask_reg;
    ram_re    = 1'b0;
    ram_raddr = base + ADDR_W'(pos);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        mod_start = accept && (op_t'(cmd.operation) == OP_ADD) && port_ok;
      end
      S_RUN: begin
        ram_re = 1'b1;
      end
      S_RD_ADDR: begin
        ram_re    = 1'b1;
        ram_raddr = base + ADDR_W'(RES_W'(idx_reg));
      end
      default: begin
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= (state == S_RUN);
      // sweep the store one word a cycle
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end else begin
        clr_addr <= '0;
      end
      // hold the result until taken
      if (state == S_RD_DATA && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // port offset registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_OFFSETS; i++) begin
        offsets[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PORT_OFFSET_0: offsets[0] <= cfg_data;
        REG_PORT_OFFSET_1: offsets[1] <= cfg_data;
        REG_PORT_OFFSET_2: offsets[2] <= cfg_data;
        REG_PORT_OFFSET_3: offsets[3] <= cfg_data;
        REG_PORT_OFFSET_4: offsets[4] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // latch the item
    if (accept) begin
      port_reg <= cmd.port;
      mask_reg <= cmd.pin_mask;
      idx_reg  <= cmd.index;
      rd_zero  <= !(port_ok && index_ok);
    end
    // wave start word: (RESOLUTION - phase) mod RESOLUTION
    if (state == S_START) begin
      pos <= (phase == '0) ? '0 : RES_W'(RESOLUTION) - phase;
      cnt <= '0;
    end
    // advance through the half period, wrapping at the last word
    if (state == S_RUN) begin
      pos     <= (pos == RES_W'(RESOLUTION - 1)) ? '0 : pos + 1'b1;
      cnt     <= cnt + 1'b1;
      wr_addr <= ram_raddr;
    end
    // capture the read word
    if (state == S_RD_DATA && out_free) begin
      out_data <= rd_zero ? '0 : ram_rdata;
    end
  end

endmodule

// File: hw/rtl/psw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1280
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/psw_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_mod_unit: phase reduction
// Reduces the phase sum mod RESOLUTION by reciprocal multiplication:
// the sum is registered, then the quotient, then the remainder, which is
// registered together with done.
// ----------------------------------------------------------------------------
module psw_mod_unit #(
  parameter int RESOLUTION = psw_pkg::RESOLUTION_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [psw_pkg::SUM_W-1:0]     sum,
  output logic                          done,
  output logic [$clog2(RESOLUTION)-1:0] phase
);
  import psw_pkg::*;

  localparam int RES_W   = $clog2(RESOLUTION);
  // reciprocal scaled by 2^SHIFT, exact for every SUM_W-bit sum
  localparam int SHIFT   = SUM_W + RES_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(RESOLUTION) - 1) /
                             longint'(RESOLUTION);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int QUO_W   = PROD_W - SHIFT;

  logic               quo_pend;
  logic               rem_pend;
  logic [SUM_W-1:0]   sum_reg;
  logic [QUO_W-1:0]   quo;
  logic [PROD_W-1:0]  prod;
  logic [RES_W-1:0]   back;
  logic [RES_W-1:0]   diff;

  // quotient by reciprocal, remainder from the low bits
  assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP_C);
  assign back = RES_W'(quo) * RES_W'(RESOLUTION);
  assign diff = sum_reg[RES_W-1:0] - back;

  // control: quotient stage, then remainder stage
  always_ff @(posedge clk) begin
    if (rst) begin
      quo_pend <= 1'b0;
      rem_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      quo_pend <= start;
      rem_pend <= quo_pend;
      done     <= rem_pend;
    end
  end

  // datapath: hold the sum, then quotient, then remainder
  always_ff @(posedge clk) begin
    if (start) begin
      sum_reg <= sum;
    end
    if (quo_pend) begin
      quo <= prod[PROD_W-1:SHIFT];
    end
    if (rem_pend) begin
      phase <= diff;
    end
  end

endmodule
